### sv/fpa_pkg.sv
// Shared action codes and sideband type for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam logic [3:0] ACT_ADD      = 4'd0;
  localparam logic [3:0] ACT_SUB      = 4'd1;
  localparam logic [3:0] ACT_MUL      = 4'd2;
  localparam logic [3:0] ACT_DIV      = 4'd3;
  localparam logic [3:0] ACT_CMP      = 4'd4;
  localparam logic [3:0] ACT_MIN      = 4'd5;
  localparam logic [3:0] ACT_MAX      = 4'd6;
  localparam logic [3:0] ACT_INC      = 4'd7;
  localparam logic [3:0] ACT_DEC      = 4'd8;
  localparam logic [3:0] ACT_FROM_INT = 4'd9;
  localparam logic [3:0] ACT_TO_INT   = 4'd10;

  // Result of every non-divide action, carried alongside the divider.
  typedef struct packed {
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
    logic        is_div;
  } side_t;

endpackage
`default_nettype wire

### sv/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
  parameter int DW = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [DW-1:0] in_dvd,
  input  wire logic [31:0]   in_den,
  input  wire logic          in_neg,
  input  wire fpa_pkg::side_t in_side,
  output logic               out_vld,
  output logic [31:0]        out_quo,
  output fpa_pkg::side_t     out_side
);

  logic           vld_r  [DW];
  logic [31:0]    rem_r  [DW];
  logic [DW-1:0]  dvd_r  [DW];
  logic [31:0]    quo_r  [DW];
  logic [31:0]    den_r  [DW];
  logic           neg_r  [DW];
  fpa_pkg::side_t side_r [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic           p_vld;
    logic [31:0]    p_rem;
    logic [DW-1:0]  p_dvd;
    logic [31:0]    p_quo;
    logic [31:0]    p_den;
    logic           p_neg;
    fpa_pkg::side_t p_side;
    logic [32:0]    trial;
    logic           fits;
    logic [32:0]    diff;

    if (i == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_dvd  = in_dvd;
      assign p_quo  = '0;
      assign p_den  = in_den;
      assign p_neg  = in_neg;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[i-1];
      assign p_rem  = rem_r[i-1];
      assign p_dvd  = dvd_r[i-1];
      assign p_quo  = quo_r[i-1];
      assign p_den  = den_r[i-1];
      assign p_neg  = neg_r[i-1];
      assign p_side = side_r[i-1];
    end

    assign trial = {p_rem, p_dvd[DW-1]};
    assign fits  = trial >= {1'b0, p_den};
    assign diff  = trial - {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // remainder stays below the divisor, so 32 bits hold it
        rem_r[i]  <= fits ? diff[31:0] : trial[31:0];
        dvd_r[i]  <= {p_dvd[DW-2:0], 1'b0};
        quo_r[i]  <= {p_quo[30:0], fits};
        den_r[i]  <= p_den;
        neg_r[i]  <= p_neg;
        side_r[i] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[DW-1];
  assign out_quo  = neg_r[DW-1] ? (32'd0 - quo_r[DW-1]) : quo_r[DW-1];
  assign out_side = side_r[DW-1];

endmodule
`default_nettype wire

### sv/fixed_point_alu_core.sv
// Top level: signed fixed-point ALU with pipelined multiply and divide.
// Every action takes the same path: stage A, the divider stages, then the output register.
// Throughput: one beat per cycle; the whole pipe advances when the output register is free.
// Depth is set by the divider, which resolves one quotient bit per stage over 32+FRAC_BITS stages.
// Reset: synchronous active-low rst_n clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_core #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_action,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result_value,
  output logic                    out_is_less,
  output logic                    out_is_equal,
  output logic                    out_is_greater,
  output logic                    out_divide_by_zero
);

  localparam int DW = 32 + FRAC_BITS;

  logic en;

  // stage A: operands and full product
  logic               vld_a_r;
  logic [3:0]         act_a_r;
  logic signed [31:0] a_a_r;
  logic signed [31:0] b_a_r;
  logic signed [63:0] prod_a_r;
  logic signed [63:0] prod_nxt;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign prod_nxt = in_operand_a * in_operand_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act_a_r  <= in_action;
      a_a_r    <= in_operand_a;
      b_a_r    <= in_operand_b;
      prod_a_r <= prod_nxt;
    end
  end

  // stage B: simple actions, divider setup
  fpa_pkg::side_t     side;
  logic signed [63:0] prod_sh;
  logic signed [DW-1:0] num;
  logic [DW-1:0]      num_abs;
  logic [31:0]        den_abs;
  logic               a_lt_b;
  logic               a_gt_b;

  assign prod_sh = prod_a_r >>> FRAC_BITS;
  assign num     = {a_a_r, {FRAC_BITS{1'b0}}};
  assign num_abs = num[DW-1] ? (DW'(0) - num) : num;
  assign den_abs = b_a_r[31] ? (32'd0 - b_a_r) : b_a_r;
  assign a_lt_b  = a_a_r < b_a_r;
  assign a_gt_b  = a_a_r > b_a_r;

  always_comb begin
    side = '0;
    case (act_a_r)
      fpa_pkg::ACT_ADD:      side.res = a_a_r + b_a_r;
      fpa_pkg::ACT_SUB:      side.res = a_a_r - b_a_r;
      fpa_pkg::ACT_MUL:      side.res = prod_sh[31:0];
      fpa_pkg::ACT_DIV: begin
        if (b_a_r == 32'sd0) begin
          side.dz = 1'b1;
        end else begin
          side.is_div = 1'b1;
        end
      end
      fpa_pkg::ACT_CMP: begin
        side.lt = a_lt_b;
        side.eq = a_a_r == b_a_r;
        side.gt = a_gt_b;
      end
      fpa_pkg::ACT_MIN:      side.res = a_lt_b ? a_a_r : b_a_r;
      fpa_pkg::ACT_MAX:      side.res = a_gt_b ? a_a_r : b_a_r;
      fpa_pkg::ACT_INC:      side.res = a_a_r + 32'sd1;
      fpa_pkg::ACT_DEC:      side.res = a_a_r - 32'sd1;
      fpa_pkg::ACT_FROM_INT: side.res = a_a_r << FRAC_BITS;
      fpa_pkg::ACT_TO_INT:   side.res = a_a_r >>> FRAC_BITS;
      default:               side = '0;
    endcase
  end

  logic           div_vld;
  logic [31:0]    div_quo;
  fpa_pkg::side_t div_side;

  fpa_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_a_r),
    .in_dvd   (num_abs),
    .in_den   (den_abs),
    .in_neg   (a_a_r[31] ^ b_a_r[31]),
    .in_side  (side),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // output register
  logic        out_valid_r;
  logic [31:0] res_r;
  logic        lt_r;
  logic        eq_r;
  logic        gt_r;
  logic        dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= div_side.is_div ? div_quo : div_side.res;
      lt_r  <= div_side.lt;
      eq_r  <= div_side.eq;
      gt_r  <= div_side.gt;
      dz_r  <= div_side.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = res_r;
  assign out_is_less        = lt_r;
  assign out_is_equal       = eq_r;
  assign out_is_greater     = gt_r;
  assign out_divide_by_zero = dz_r;

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the fixed-point ALU core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int FRAC = 8;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int errors;

    function alu_res_t compute(logic [3:0] act, logic signed [31:0] a,
                               logic signed [31:0] b);
      alu_res_t r;
      logic signed [63:0] wide;
      r = '0;
      case (act)
        fpa_pkg::ACT_ADD: r.value = a + b;
        fpa_pkg::ACT_SUB: r.value = a - b;
        fpa_pkg::ACT_MUL: begin
          wide = 64'(a) * 64'(b);
          r.value = 32'(wide >>> FRAC);
        end
        fpa_pkg::ACT_DIV: begin
          if (b == 0) begin
            r.dz = 1'b1;
          end else begin
            wide = 64'(a) <<< FRAC;
            r.value = 32'(wide / 64'(b));
          end
        end
        fpa_pkg::ACT_CMP: begin
          r.lt = a < b;
          r.eq = a == b;
          r.gt = a > b;
        end
        fpa_pkg::ACT_MIN: r.value = (a < b) ? a : b;
        fpa_pkg::ACT_MAX: r.value = (a > b) ? a : b;
        fpa_pkg::ACT_INC: r.value = a + 32'sd1;
        fpa_pkg::ACT_DEC: r.value = a - 32'sd1;
        fpa_pkg::ACT_FROM_INT: r.value = a << FRAC;
        fpa_pkg::ACT_TO_INT: r.value = a >>> FRAC;
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_input(logic [3:0] act, logic signed [31:0] a,
                             logic signed [31:0] b);
      pending.push_back(compute(act, a, b));
    endfunction

    function void check_result(alu_res_t got);
      alu_res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value) begin
        $display("%0t: result_value exp %h got %h", $realtime, exp.value, got.value);
        errors++;
      end
      if (got.lt !== exp.lt) begin
        $display("%0t: is_less exp %b got %b", $realtime, exp.lt, got.lt);
        errors++;
      end
      if (got.eq !== exp.eq) begin
        $display("%0t: is_equal exp %b got %b", $realtime, exp.eq, got.eq);
        errors++;
      end
      if (got.gt !== exp.gt) begin
        $display("%0t: is_greater exp %b got %b", $realtime, exp.gt, got.gt);
        errors++;
      end
      if (got.dz !== exp.dz) begin
        $display("%0t: divide_by_zero exp %b got %b", $realtime, exp.dz, got.dz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_action = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_result_value;
  logic out_is_less, out_is_equal, out_is_greater, out_divide_by_zero;

  int send_idle_pct = 33;
  int recv_idle_pct = 63;
  alu_scoreboard sb = new();

  fixed_point_alu_core #(.FRAC_BITS(FRAC)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_operand_a, .in_operand_b,
    .out_valid, .out_ready, .out_result_value, .out_is_less, .out_is_equal,
    .out_is_greater, .out_divide_by_zero
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random backpressure, checks each accepted beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result({out_result_value, out_is_less, out_is_equal,
                         out_is_greater, out_divide_by_zero});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 2)) - 32'd1;
      3: return 32'($signed($urandom_range(0, 4096)) - 2048);
      4: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, a, b);
  endtask

  task automatic run_phase(int count);
    repeat (count)
      send_beat(4'($urandom_range(15)), pick_operand(), pick_operand());
  endtask

  initial begin
    int wait_cycles;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners: every action, extremes, divide by zero, equal compare
    for (int act = 0; act < 16; act++)
      send_beat(4'(act), 32'h8000_0000, 32'h7fff_ffff);
    send_beat(fpa_pkg::ACT_DIV, 32'h0000_0100, 32'h0);
    send_beat(fpa_pkg::ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(fpa_pkg::ACT_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_beat(fpa_pkg::ACT_CMP, 32'h1234_5678, 32'h1234_5678);
    send_beat(fpa_pkg::ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(fpa_pkg::ACT_INC, 32'h7fff_ffff, 32'h0);
    send_beat(fpa_pkg::ACT_DEC, 32'h8000_0000, 32'hffff_ffff);
    send_beat(fpa_pkg::ACT_TO_INT, 32'hffff_ff01, 32'h0);
    run_phase(215);
    send_idle_pct = 63;
    recv_idle_pct = 33;
    run_phase(215);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(200);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (FRAC + 40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("fixed_point_alu_core regression: pass");
    else
      $display("fixed_point_alu_core regression: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fixed_point_alu_core regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
